@@ rtl/step_profile_thermostat_macros.svh @@
// Assertion macros shared by the thermostat checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef STEP_PROFILE_THERMOSTAT_MACROS_SVH
`define STEP_PROFILE_THERMOSTAT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thermostat check failed");

// Next-cycle implication, disabled during reset
`define SPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thermostat check failed");

`endif

@@ rtl/spt_pkg.sv @@
// Shared types, codes and bus layout for the step profile thermostat.
// No dependencies; imported by every module of the block.
package spt_pkg;

  localparam int DEF_NUM_INTERVALS = 16;

  // Field widths
  localparam int OP_W     = 2;
  localparam int TEMP_W   = 8;
  localparam int IDX_W    = 4;
  localparam int TIME_W   = 16;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Bus widths and field offsets
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  localparam int IN_TEMP_LSB   = 0;
  localparam int IN_VALID_BIT  = 8;
  localparam int IN_IDX_LSB    = 9;
  localparam int IN_TGT_LSB    = 13;
  localparam int IN_HOLD_LSB   = 21;
  localparam int IN_TIME_LSB   = 37;

  localparam int OUT_HEATER_BIT  = 0;
  localparam int OUT_HLED_BIT    = 1;
  localparam int OUT_CLED_BIT    = 2;
  localparam int OUT_HEATING_BIT = 3;
  localparam int OUT_PAUSED_BIT  = 4;
  localparam int OUT_IDX_LSB     = 5;
  localparam int OUT_REM_LSB     = 9;
  localparam int OUT_FAULT_BIT   = 25;

  // Drive pin bit positions
  localparam int PIN_HEATER     = 0;
  localparam int PIN_HEATER_LED = 1;
  localparam int PIN_COOLER_LED = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'd1;

  localparam logic [CFG_W-1:0] BAND_RESET = 8'd2;
  localparam logic [CFG_W-1:0] STEP_RESET = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TEMP_W-1:0] temp;
    logic              temp_valid;
    logic [IDX_W-1:0]  entry_index;
    logic [TEMP_W-1:0] entry_target;
    logic [TIME_W-1:0] entry_hold;
    logic [TIME_W-1:0] entry_time;
  } in_item_t;

  typedef struct packed {
    logic              heater_on;
    logic              heater_led;
    logic              cooler_led;
    logic              heating;
    logic              paused;
    logic [IDX_W-1:0]  interval_index;
    logic [TIME_W-1:0] remaining;
    logic              sensor_fault;
  } out_item_t;

  // Table write request from the core
  typedef struct packed {
    logic              entry_we;
    logic              time_we;
    logic [IDX_W-1:0]  addr;
    logic [TEMP_W-1:0] tgt;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] remain;
  } wr_req_t;

  // Registered table reads: slot s and slot s+1
  typedef struct packed {
    logic [TEMP_W-1:0] tgt0;
    logic [TIME_W-1:0] hold0;
    logic [TIME_W-1:0] hold1;
    logic [TIME_W-1:0] time0;
    logic [TIME_W-1:0] time1;
  } rd_data_t;

endpackage

@@ rtl/step_profile_thermostat.sv @@
// Step profile thermostat: input and output registers around the update core.
// Instantiates spt_tables and spt_core; uses spt_pkg.
//
// Usage:
//   in_*   : one word per item. in_tuser selects tick, load of an interval
//            entry, or start of the profile; in_tdata carries the sample and
//            the entry fields.
//   out_*  : one result word for every input word, in order: pin levels,
//            heating flag, pause flag, slot, remaining time, sensor fault.
//   cfg_*  : register writes (band, step_seconds); write only while idle, a rule the block leaves to the user.
// Timing:
//   The accepting edge loads the input register and the registered table read
//   ports together; once the output register is free or draining, the next
//   edge loads the update result into the output register.
//   Throughput is one word per cycle while out_tready is high.
// Reset: slot 0, profile paused, heater and LEDs off, band 2, step 10. The
//   interval tables are not cleared; load an entry before it is used.
// Stall: while out_tready is low the result is held; one more word is taken
//   into the input register, then in_tready drops until the output drains.
module step_profile_thermostat #(
  parameter int NUM_INTERVALS = spt_pkg::DEF_NUM_INTERVALS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [spt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spt_pkg::CFG_W-1:0]          cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata, low bit up: temp[8], temp_valid[1], entry_index[4],
  // entry_target[8], entry_hold[16], entry_time[16], zero pad[3]
  input  logic [spt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: operation[2]
  input  logic [spt_pkg::OP_W-1:0]           in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, low bit up: heater_on, heater_led, cooler_led, heating, paused,
  // interval_index[4], remaining[16], sensor_fault, zero pad[6]
  output logic [spt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import spt_pkg::*;

  localparam int SLOT_W = $clog2(NUM_INTERVALS);

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  in_item_t          in_item;
  logic              accept, fire;
  logic [SLOT_W-1:0] slot_base, rd_base;
  rd_data_t          rd;
  wr_req_t           wr;
  out_item_t         result;

  // Unpack the input word
  always_comb begin
    in_item.op           = in_tuser;
    in_item.temp         = in_tdata[IN_TEMP_LSB +: TEMP_W];
    in_item.temp_valid   = in_tdata[IN_VALID_BIT];
    in_item.entry_index  = in_tdata[IN_IDX_LSB +: IDX_W];
    in_item.entry_target = in_tdata[IN_TGT_LSB +: TEMP_W];
    in_item.entry_hold   = in_tdata[IN_HOLD_LSB +: TIME_W];
    in_item.entry_time   = in_tdata[IN_TIME_LSB +: TIME_W];
  end

  // Handshake: process when the output register is free or draining
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Tables are read at the slot the word will see; a start always sees slot 0
  assign rd_base = (in_item.op == OP_START) ? '0 : slot_base;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  spt_tables #(.NUM_INTERVALS(NUM_INTERVALS)) u_tables (
    .clk     (clk),
    .rd_en   (accept),
    .rd_base (rd_base),
    .wr      (wr),
    .rd      (rd)
  );

  spt_core #(.NUM_INTERVALS(NUM_INTERVALS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item_r),
    .rd        (rd),
    .wr        (wr),
    .slot_base (slot_base),
    .result    (result)
  );

  // Pack the result word
  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata                                  = '0;
    out_tdata[OUT_HEATER_BIT]                  = out_item_r.heater_on;
    out_tdata[OUT_HLED_BIT]                    = out_item_r.heater_led;
    out_tdata[OUT_CLED_BIT]                    = out_item_r.cooler_led;
    out_tdata[OUT_HEATING_BIT]                 = out_item_r.heating;
    out_tdata[OUT_PAUSED_BIT]                  = out_item_r.paused;
    out_tdata[OUT_IDX_LSB +: IDX_W]            = out_item_r.interval_index;
    out_tdata[OUT_REM_LSB +: TIME_W]           = out_item_r.remaining;
    out_tdata[OUT_FAULT_BIT]                   = out_item_r.sensor_fault;
  end

endmodule

@@ rtl/spt_tables.sv @@
// Interval tables: target, hold and remaining time per slot.
// Registered reads at a base slot and the slot after it, with write bypass. Uses spt_pkg.
module spt_tables #(
  parameter int NUM_INTERVALS = spt_pkg::DEF_NUM_INTERVALS
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [$clog2(NUM_INTERVALS)-1:0]  rd_base,
  input  spt_pkg::wr_req_t                  wr,
  output spt_pkg::rd_data_t                 rd
);
  import spt_pkg::*;

  localparam int SLOT_W = $clog2(NUM_INTERVALS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_INTERVALS - 1);

  logic [TEMP_W-1:0] tgt_mem  [NUM_INTERVALS];
  logic [TIME_W-1:0] hold_mem [NUM_INTERVALS];
  logic [TIME_W-1:0] time_mem [NUM_INTERVALS];

  logic [SLOT_W-1:0] wa;
  logic [SLOT_W-1:0] ra1;
  logic              time_wr;
  rd_data_t          rd_r;

  assign wa      = wr.addr[SLOT_W-1:0];
  assign time_wr = wr.entry_we || wr.time_we;
  assign ra1     = (rd_base == LAST_SLOT) ? '0 : rd_base + SLOT_W'(1);
  assign rd      = rd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.entry_we) begin
      tgt_mem[wa]  <= wr.tgt;
      hold_mem[wa] <= wr.hold;
    end
    if (time_wr) begin
      time_mem[wa] <= wr.remain;
    end
  end

  // Read ports, write-through on an address match
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.tgt0  <= (wr.entry_we && wa == rd_base) ? wr.tgt    : tgt_mem[rd_base];
      rd_r.hold0 <= (wr.entry_we && wa == rd_base) ? wr.hold   : hold_mem[rd_base];
      rd_r.hold1 <= (wr.entry_we && wa == ra1)     ? wr.hold   : hold_mem[ra1];
      rd_r.time0 <= (time_wr && wa == rd_base)     ? wr.remain : time_mem[rd_base];
      rd_r.time1 <= (time_wr && wa == ra1)         ? wr.remain : time_mem[ra1];
    end
  end

endmodule

@@ rtl/spt_core.sv @@
// Profile state, configuration registers and the per-word update logic.
// Reads slot entries from spt_tables and issues table writes. Uses spt_pkg.
module spt_core #(
  parameter int NUM_INTERVALS = spt_pkg::DEF_NUM_INTERVALS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [spt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spt_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              fire,
  input  spt_pkg::in_item_t                 item,
  input  spt_pkg::rd_data_t                 rd,
  output spt_pkg::wr_req_t                  wr,
  output logic [$clog2(NUM_INTERVALS)-1:0]  slot_base,
  output spt_pkg::out_item_t                result
);
  import spt_pkg::*;

  localparam int SLOT_W = $clog2(NUM_INTERVALS);
  localparam logic [SLOT_W:0] LAST_CMP = (SLOT_W+1)'(NUM_INTERVALS - 1);
  localparam logic [IDX_W:0]  NUM_CMP  = (IDX_W+1)'(NUM_INTERVALS);

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              pause_r, pause_nxt;
  logic              heat_r, heat_nxt;
  logic [2:0]        pins_r, pins_nxt;
  logic [CFG_W-1:0]  band_r, step_r;

  logic [SLOT_W-1:0] slot_inc;
  logic [TEMP_W+1:0] temp_x, tgt_x, band_x;
  logic              below, above;
  logic [TIME_W-1:0] step_x, time_new;
  logic [TIME_W-1:0] remain_o;
  logic              fault;
  wr_req_t           wr_c;

  assign slot_inc = slot_r + SLOT_W'(1);
  assign temp_x   = {2'b00, item.temp};
  assign tgt_x    = {2'b00, rd.tgt0};
  assign band_x   = {2'b00, band_r};
  assign below    = (temp_x + band_x) < tgt_x;
  assign above    = temp_x > (tgt_x + band_x);
  assign step_x   = {8'b0, step_r};

  // Timer: preheat waits for target, otherwise saturating countdown
  always_comb begin
    if (rd.time0 > rd.hold0) begin
      time_new = (item.temp >= rd.tgt0) ? rd.hold0 : rd.time0;
    end else if (rd.time0 > step_x) begin
      time_new = rd.time0 - step_x;
    end else begin
      time_new = '0;
    end
  end

  // Next state for the word being processed
  always_comb begin
    slot_nxt  = slot_r;
    pause_nxt = pause_r;
    heat_nxt  = heat_r;
    pins_nxt  = pins_r;
    fault     = 1'b0;
    remain_o  = rd.time0;
    wr_c      = '0;
    case (item.op)
      OP_TICK: begin
        if (item.temp_valid && !pause_r) begin
          if (below) begin
            heat_nxt = 1'b1;
            pins_nxt[PIN_HEATER]     = 1'b1;
            pins_nxt[PIN_HEATER_LED] = 1'b1;
          end
          if (above) begin
            heat_nxt = 1'b0;
            pins_nxt[PIN_HEATER]     = 1'b0;
            pins_nxt[PIN_HEATER_LED] = 1'b0;
          end
          wr_c.time_we = 1'b1;
          wr_c.addr    = IDX_W'(slot_r);
          wr_c.remain  = time_new;
          remain_o     = time_new;
          // interval done: move on, pause at the end of the profile
          if (time_new == '0) begin
            slot_nxt = slot_inc;
            remain_o = rd.time1;
            if (({1'b0, slot_inc} >= LAST_CMP) || rd.hold1 == '0) begin
              pause_nxt = 1'b1;
            end
          end
        end else if (!pause_r) begin
          // sensor fault: both LEDs lit, heater off
          fault    = 1'b1;
          pins_nxt[PIN_HEATER]     = 1'b0;
          pins_nxt[PIN_HEATER_LED] = 1'b1;
          pins_nxt[PIN_COOLER_LED] = 1'b1;
        end else if (({1'b0, slot_r} >= LAST_CMP) || rd.hold0 == '0) begin
          pins_nxt = '0;
        end
      end
      OP_LOAD: begin
        if ({1'b0, item.entry_index} < NUM_CMP) begin
          wr_c.entry_we = 1'b1;
          wr_c.addr     = item.entry_index;
          wr_c.tgt      = item.entry_target;
          wr_c.hold     = item.entry_hold;
          wr_c.remain   = item.entry_time;
          if (item.entry_index == IDX_W'(slot_r)) begin
            remain_o = item.entry_time;
          end
        end
      end
      OP_START: begin
        pause_nxt = 1'b0;
        slot_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  assign wr = fire ? wr_c : '0;
  assign slot_base = fire ? slot_nxt : slot_r;

  always_comb begin
    result.heater_on      = pins_nxt[PIN_HEATER];
    result.heater_led     = pins_nxt[PIN_HEATER_LED];
    result.cooler_led     = pins_nxt[PIN_COOLER_LED];
    result.heating        = heat_nxt;
    result.paused         = pause_nxt;
    result.interval_index = IDX_W'(slot_nxt);
    result.remaining      = remain_o;
    result.sensor_fault   = fault;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      pause_r <= 1'b1;
      heat_r  <= 1'b0;
      pins_r  <= '0;
    end else if (fire) begin
      slot_r  <= slot_nxt;
      pause_r <= pause_nxt;
      heat_r  <= heat_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= BAND_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BAND: band_r <= cfg_wdata;
        CFG_STEP: step_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/spt_checker.sv @@
// Port-level checks for the step profile thermostat, bound to the top level.
// Uses spt_pkg and the macros in step_profile_thermostat_macros.svh.
`include "step_profile_thermostat_macros.svh"

module spt_checker #(
  parameter int NUM_INTERVALS = spt_pkg::DEF_NUM_INTERVALS
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [spt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import spt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_INTERVALS - 1);

  logic fault_w, paused_w, hon_w, hled_w, cled_w;
  logic [IDX_W-1:0] idx_w;

  assign fault_w  = out_tdata[OUT_FAULT_BIT];
  assign paused_w = out_tdata[OUT_PAUSED_BIT];
  assign hon_w    = out_tdata[OUT_HEATER_BIT];
  assign hled_w   = out_tdata[OUT_HLED_BIT];
  assign cled_w   = out_tdata[OUT_CLED_BIT];
  assign idx_w    = out_tdata[OUT_IDX_LSB +: IDX_W];

  // stalled result word holds
  `SPT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a new result follows an accepted input word
  `SPT_ASSERT_SAME(a_out_from_in, $rose(out_tvalid), $past(in_tvalid && in_tready, 2))

  // fault word: profile running, both LEDs lit, heater off
  `SPT_ASSERT_SAME(a_fault_pins, out_tvalid && fault_w, !paused_w && hled_w && cled_w && !hon_w)

  // heater never driven without its LED; a running profile is before the last slot
  `SPT_ASSERT_SAME(a_run_state, out_tvalid, (!hon_w || hled_w) && (paused_w || idx_w < LAST_IDX))

endmodule

bind step_profile_thermostat spt_checker #(.NUM_INTERVALS(NUM_INTERVALS)) u_spt_checker (.*);

@@ tb/sv/step_profile_thermostat_checker.sv @@
// Checker for the step profile thermostat: watches the config, input and result
// ports, predicts every result word and compares it field by field.
// Depends on spt_pkg for widths, bus offsets, codes and the result struct.
`timescale 1ns / 1ps

module step_profile_thermostat_checker #(
  parameter int NUM_INTERVALS = spt_pkg::DEF_NUM_INTERVALS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spt_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // tdata, low bit up: temp[8], temp_valid[1], entry_index[4],
  // entry_target[8], entry_hold[16], entry_time[16], zero pad[3]
  input  logic [spt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: operation[2]
  input  logic [spt_pkg::OP_W-1:0]        in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata, low bit up: heater_on, heater_led, cooler_led, heating, paused,
  // interval_index[4], remaining[16], sensor_fault, zero pad[6]
  input  logic [spt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              outstanding
);
  import spt_pkg::*;

  localparam int SLOTS = 2 ** IDX_W;

  // Predicted block state
  logic [TEMP_W-1:0] tgt_tab    [SLOTS];
  logic [TIME_W-1:0] hold_tab   [SLOTS];
  logic [TIME_W-1:0] remain_tab [SLOTS];
  logic [IDX_W-1:0]  slot_q;
  logic              paused_q;
  logic              heat_q;
  logic [2:0]        pins_q;
  logic [CFG_W-1:0]  band_q;
  logic [CFG_W-1:0]  step_q;

  out_item_t expected_q [$];
  int        mismatches = 0;

  // Apply one input word to the predicted state, return the expected result
  function automatic out_item_t update_thermostat(logic [OP_W-1:0] op,
                                                   logic [IN_TDATA_W-1:0] d);
    logic [TEMP_W-1:0] temp;
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  s;
    int                t;
    int                tv;
    int                b;
    logic              fault;
    out_item_t         r;
    temp  = d[IN_TEMP_LSB +: TEMP_W];
    valid = d[IN_VALID_BIT];
    idx   = d[IN_IDX_LSB +: IDX_W];
    fault = 1'b0;
    case (op)
      OP_TICK: begin
        if (!paused_q && valid) begin
          s  = slot_q;
          t  = int'(tgt_tab[s]);
          tv = int'(temp);
          b  = int'(band_q);
          // hysteresis band, signed so the limits may leave 0..255
          if (tv < t - b) begin
            heat_q = 1'b1;
            pins_q[PIN_HEATER] = 1'b1;
            pins_q[PIN_HEATER_LED] = 1'b1;
          end
          if (tv > t + b) begin
            heat_q = 1'b0;
            pins_q[PIN_HEATER] = 1'b0;
            pins_q[PIN_HEATER_LED] = 1'b0;
          end
          // preheat holds the timer until the target is reached
          if (remain_tab[s] > hold_tab[s]) begin
            if (tv >= t) remain_tab[s] = hold_tab[s];
          end else if (remain_tab[s] > TIME_W'(step_q)) begin
            remain_tab[s] = remain_tab[s] - TIME_W'(step_q);
          end else begin
            remain_tab[s] = '0;
          end
          // timer expired: next slot, pause at the last one or a zero hold
          if (remain_tab[s] == '0) begin
            slot_q = s + IDX_W'(1);
            if (int'(slot_q) >= NUM_INTERVALS - 1 || hold_tab[slot_q] == '0) paused_q = 1'b1;
          end
        end else if (!paused_q) begin
          // running tick with a bad sample
          fault = 1'b1;
          pins_q[PIN_HEATER_LED] = 1'b1;
          pins_q[PIN_COOLER_LED] = 1'b1;
          pins_q[PIN_HEATER] = 1'b0;
        end else if (int'(slot_q) >= NUM_INTERVALS - 1 || hold_tab[slot_q] == '0) begin
          pins_q = '0;
        end
      end
      OP_LOAD: begin
        if (int'(idx) < NUM_INTERVALS) begin
          tgt_tab[idx]    = d[IN_TGT_LSB +: TEMP_W];
          hold_tab[idx]   = d[IN_HOLD_LSB +: TIME_W];
          remain_tab[idx] = d[IN_TIME_LSB +: TIME_W];
        end
      end
      OP_START: begin
        paused_q = 1'b0;
        slot_q   = '0;
      end
      default: ;
    endcase
    r.heater_on      = pins_q[PIN_HEATER];
    r.heater_led     = pins_q[PIN_HEATER_LED];
    r.cooler_led     = pins_q[PIN_COOLER_LED];
    r.heating        = heat_q;
    r.paused         = paused_q;
    r.interval_index = slot_q;
    r.remaining      = remain_tab[slot_q];
    r.sensor_fault   = fault;
    return r;
  endfunction

  task automatic check_field(string name, logic [TIME_W-1:0] e, logic [TIME_W-1:0] a);
    if (e !== a) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
    end
  endtask

  task automatic compare_result(out_item_t e, logic [OUT_TDATA_W-1:0] w);
    check_field("heater_on", TIME_W'(e.heater_on), TIME_W'(w[OUT_HEATER_BIT]));
    check_field("heater_led", TIME_W'(e.heater_led), TIME_W'(w[OUT_HLED_BIT]));
    check_field("cooler_led", TIME_W'(e.cooler_led), TIME_W'(w[OUT_CLED_BIT]));
    check_field("heating", TIME_W'(e.heating), TIME_W'(w[OUT_HEATING_BIT]));
    check_field("paused", TIME_W'(e.paused), TIME_W'(w[OUT_PAUSED_BIT]));
    check_field("interval_index", TIME_W'(e.interval_index),
                TIME_W'(w[OUT_IDX_LSB +: IDX_W]));
    check_field("remaining", e.remaining, w[OUT_REM_LSB +: TIME_W]);
    check_field("sensor_fault", TIME_W'(e.sensor_fault), TIME_W'(w[OUT_FAULT_BIT]));
  endtask

  // Register writes, then accepted input words, then accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      slot_q   = '0;
      paused_q = 1'b1;
      heat_q   = 1'b0;
      pins_q   = '0;
      band_q   = BAND_RESET;
      step_q   = STEP_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BAND: band_q = cfg_wdata;
          CFG_STEP: step_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_q.push_back(update_thermostat(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          compare_result(expected_q.pop_front(), out_tdata);
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= expected_q.size();
  end

endmodule

@@ tb/sv/tb_step_profile_thermostat.sv @@
// Testbench top for the step profile thermostat: clock, reset, stimulus,
// receiver back-pressure and the verdict. Checking is done by
// step_profile_thermostat_checker; types and offsets come from spt_pkg.
`timescale 1ns / 1ps

module tb_step_profile_thermostat;
  import spt_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int PHASE_WORDS     = 70;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES    = 4;
  localparam int TIMEOUT_NS      = 2_000_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int   fail_count;
  int   outstanding;
  int   words_sent = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_off_req;

  step_profile_thermostat i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  step_profile_thermostat_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_word(
    logic [TEMP_W-1:0] temp, logic valid, logic [IDX_W-1:0] idx,
    logic [TEMP_W-1:0] tgt, logic [TIME_W-1:0] hold, logic [TIME_W-1:0] span);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[IN_TEMP_LSB +: TEMP_W] = temp;
    w[IN_VALID_BIT]          = valid;
    w[IN_IDX_LSB +: IDX_W]   = idx;
    w[IN_TGT_LSB +: TEMP_W]  = tgt;
    w[IN_HOLD_LSB +: TIME_W] = hold;
    w[IN_TIME_LSB +: TIME_W] = span;
    return w;
  endfunction

  // Offer one word after a random gap; returns at the accepting edge
  task automatic send_word(op_t op, logic [IN_TDATA_W-1:0] d);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Unused fields of a word carry random noise
  task automatic send_load(logic [IDX_W-1:0] idx, logic [TEMP_W-1:0] tgt,
                           logic [TIME_W-1:0] hold, logic [TIME_W-1:0] span);
    send_word(OP_LOAD, pack_word(TEMP_W'($urandom), 1'($urandom), idx, tgt, hold, span));
  endtask

  task automatic send_tick(logic [TEMP_W-1:0] temp, logic valid);
    send_word(OP_TICK, pack_word(temp, valid, IDX_W'($urandom), TEMP_W'($urandom),
                                 TIME_W'($urandom), TIME_W'($urandom)));
  endtask

  task automatic send_start();
    send_word(OP_START, pack_word(TEMP_W'($urandom), 1'($urandom), IDX_W'($urandom),
                                  TEMP_W'($urandom), TIME_W'($urandom), TIME_W'($urandom)));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop offering and wait until every expected result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly short intervals near room-to-brew targets, some extremes
  task automatic send_random_load();
    logic [TEMP_W-1:0] tgt;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] span;
    int                r;
    r = $urandom_range(99);
    tgt = TEMP_W'((r < 80) ? $urandom_range(80, 60) : $urandom_range(255));
    r = $urandom_range(99);
    if (r < 12) hold = '0;
    else if (r < 80) hold = TIME_W'($urandom_range(40, 1));
    else if (r < 95) hold = TIME_W'($urandom_range(400, 41));
    else hold = TIME_W'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 15) span = '0;
    else if (r < 70) span = TIME_W'($urandom_range(60));
    else if (r < 90) span = (hold > 16'hFF00) ? 16'hFFFF : hold + TIME_W'($urandom_range(40, 1));
    else span = TIME_W'($urandom_range(65535));
    send_load(IDX_W'($urandom_range(15)), tgt, hold, span);
  endtask

  // A profile run: a few loads, usually a start, then ticks with some noise mixed in
  task automatic run_profile_burst();
    int r;
    repeat ($urandom_range(3)) send_random_load();
    if ($urandom_range(9) != 0) send_start();
    repeat ($urandom_range(20, 5)) begin
      r = $urandom_range(99);
      if (r < 4) send_random_load();
      else if (r < 6) send_start();
      else send_tick(TEMP_W'(($urandom_range(99) < 80) ? $urandom_range(90, 50)
                                                        : $urandom_range(255)),
                     $urandom_range(99) < 92);
    end
  endtask

  task automatic run_phase(idle_mode_t mode, logic [CFG_W-1:0] band_v,
                           logic [CFG_W-1:0] step_v, bit hold_off);
    int stop_at;
    write_reg(CFG_BAND, band_v);
    write_reg(CFG_STEP, step_v);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 64; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 64; end
      IDLE_BOTH:     begin gap_pct = 16; stall_pct = 16; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
    if (hold_off) hold_off_req = 1'b1;
    stop_at = words_sent + PHASE_WORDS;
    while (words_sent < stop_at) run_profile_burst();
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_BAND;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_TICK;
    hold_off_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every slot, slot 0 first, so no unwritten entry is ever read
    for (int i = 0; i < 16; i++) begin
      if (i == 0) send_load(IDX_W'(i), 8'd255, 16'd5, 16'd20);      // preheat, top target
      else if (i == 1) send_load(IDX_W'(i), 8'd0, 16'd3, 16'd3);    // target zero
      else if (i == 2) send_load(IDX_W'(i), 8'd100, 16'd0, 16'd0);  // end of profile
      else if (i == 15) send_load(IDX_W'(i), 8'd128, 16'hFFFF, 16'hFFFF);
      else send_load(IDX_W'(i), 8'd70, 16'd8, 16'd12);
    end

    // Directed walk through slots 0..2
    send_tick(8'd50, 1'b1);    // paused with nonzero hold: no change
    send_start();
    send_tick(8'd0, 1'b1);     // far below target: heat, preheat holds
    send_tick(8'd255, 1'b1);   // target reached: timer set to hold
    send_tick(8'd255, 1'b0);   // bad sample while running: fault
    send_tick(8'd255, 1'b1);   // timer expires: on to slot 1
    send_tick(8'd0, 1'b1);     // band below zero; expires into zero-hold slot
    send_tick(8'd77, 1'b1);    // paused on zero hold: pins cleared
    send_load(4'd2, 8'd70, 16'd4, 16'd4);
    send_start();              // consumed times stay consumed
    send_tick(8'd90, 1'b1);
    drain();

    run_phase(IDLE_NONE, BAND_RESET, STEP_RESET, 1'b0);
    run_phase(IDLE_SENDER, 8'd0, 8'd1, 1'b0);
    run_phase(IDLE_RECEIVER, 8'd255, 8'd255, 1'b0);
    run_phase(IDLE_BOTH, 8'd5, 8'd3, 1'b0);
    run_phase(IDLE_NONE, CFG_W'($urandom_range(255)), CFG_W'($urandom_range(255, 1)), 1'b1);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/spt_pkg.sv
rtl/spt_tables.sv
rtl/spt_core.sv
rtl/step_profile_thermostat.sv
rtl/spt_checker.sv
tb/sv/step_profile_thermostat_checker.sv
tb/sv/tb_step_profile_thermostat.sv
